### hdl/lir_pkg.sv
// Package for the linear interpolation resampler: constants, register indexes and state type.
package lir_pkg;

  localparam int unsigned SRC_DEPTH = 4096;
  localparam int unsigned ADDR_W    = $clog2(SRC_DEPTH);
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned COUNT_W   = 13;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PROD_W    = IDX_W + 1 + POS_W;
  localparam int unsigned ACC_W     = FRAC_BITS + SAMPLE_W + 1;

  localparam logic [FRAC_BITS:0] FIX_ONE  = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic [ACC_W-1:0]   FIX_HALF = ACC_W'(1) << (FRAC_BITS - 1);

  localparam logic [CFG_IDX_W-1:0] REG_SRC_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_POS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP      = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);
  localparam logic [POS_W-1:0]   START_RESET = '0;
  localparam logic [POS_W-1:0]   STEP_RESET  = POS_W'(1) << FRAC_BITS;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_RDA,
    ST_RDB,
    ST_MAC
  } state_e;

endpackage

### hdl/lir_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lir_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/linear_interp_resampler_unit.sv
// Top level of the linear interpolation resampler: sample memory, position datapath, control.
//
// Usage: an item is taken at a clock edge with start high and busy low.
// cmd_i = load writes sample_value_i to the sample memory at index_i;
// busy stays low, so loads can be issued every cycle.
// cmd_i = compute forms start_pos + index*step (signed 16.16), checks it
// against [0, src_count-1] and interpolates between the two neighboring
// samples. The result word shows on out_* for exactly one cycle with
// out_valid_o high; busy is high until then, and the next item may be
// started in the cycle that the result is shown. The compute path runs
// through the multiply stage, the range check and, when in range, two
// reads of the single read port of the sample memory, one per neighbor,
// followed by a multiply-accumulate. Configuration writes (cfg_we_i,
// cfg_idx_i, cfg_wdata_i) take effect at once; the user must make them
// only while idle, as the block itself does not enforce it. Reset clears
// control state and the registers to src_count 1, start_pos 0, step 1.0;
// sample memory contents are undefined until loaded. The receiver cannot stall results.
module linear_interp_resampler_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cmd_i,
  input  logic [lir_pkg::IDX_W-1:0]           index_i,
  input  logic [lir_pkg::SAMPLE_W-1:0]        sample_value_i,
  input  logic                                cfg_we_i,
  input  logic [lir_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [lir_pkg::CFG_W-1:0]           cfg_wdata_i,
  output logic                                out_valid_o,
  output logic [lir_pkg::IDX_W-1:0]           out_index_o,
  output logic [lir_pkg::SAMPLE_W-1:0]        out_value_o,
  output logic                                out_of_range_o
);

  lir_pkg::state_e state_q, state_d;

  logic [lir_pkg::COUNT_W-1:0]  count_q;
  logic signed [lir_pkg::POS_W-1:0] start_pos_q;
  logic signed [lir_pkg::POS_W-1:0] step_q;

  logic [lir_pkg::IDX_W-1:0]        idx_q;
  logic signed [lir_pkg::PROD_W-1:0] prod_q;
  logic [lir_pkg::ADDR_W-1:0]       j_q;
  logic [lir_pkg::FRAC_BITS-1:0]    f_q;
  logic [lir_pkg::ACC_W-1:0]        acc_q;

  logic                             out_valid_q;
  logic [lir_pkg::IDX_W-1:0]        out_index_q;
  logic [lir_pkg::SAMPLE_W-1:0]     out_value_q;
  logic                             out_oor_q;

  logic                             ram_we;
  logic [lir_pkg::ADDR_W-1:0]       ram_raddr;
  logic [lir_pkg::SAMPLE_W-1:0]     ram_rdata;

  logic                             accept;
  logic signed [lir_pkg::PROD_W-1:0] pos;
  logic [lir_pkg::COUNT_W-1:0]      count_sat;
  logic [lir_pkg::ADDR_W-1:0]       count_m1;
  logic [lir_pkg::PROD_W-1:0]       limit;
  logic                             in_range;
  logic [lir_pkg::ACC_W-1:0]        acc_d;
  logic [lir_pkg::SAMPLE_W-1:0]     b_sel;

  assign accept = start && !busy;

  lir_ram #(
    .WIDTH (lir_pkg::SAMPLE_W),
    .DEPTH (lir_pkg::SRC_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (index_i[lir_pkg::ADDR_W-1:0]),
    .wdata_i (sample_value_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // range check on the registered product
  always_comb begin
    pos       = lir_pkg::PROD_W'(start_pos_q) + prod_q;
    count_sat = (count_q > lir_pkg::COUNT_W'(lir_pkg::SRC_DEPTH)) ?
                lir_pkg::COUNT_W'(lir_pkg::SRC_DEPTH) : count_q;
    count_m1  = lir_pkg::ADDR_W'(count_sat - lir_pkg::COUNT_W'(1));
    limit     = lir_pkg::PROD_W'({count_m1, lir_pkg::FRAC_BITS'(0)});
    in_range  = (count_sat != '0) && !pos[lir_pkg::PROD_W-1] &&
                ($unsigned(pos) <= limit);
  end

  // second neighbor carries zero weight when the fraction is zero
  always_comb begin
    b_sel = (f_q == '0) ? '0 : ram_rdata;
    acc_d = acc_q + lir_pkg::ACC_W'(f_q * b_sel) + lir_pkg::FIX_HALF;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lir_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    ram_we    = 1'b0;
    ram_raddr = j_q;
    unique case (state_q)
      lir_pkg::ST_IDLE: begin
        if (start) begin
          if (cmd_i == lir_pkg::CMD_LOAD) begin
            ram_we = 1'b1;
          end else begin
            state_d = lir_pkg::ST_MUL;
          end
        end
      end
      lir_pkg::ST_MUL: state_d = lir_pkg::ST_CHK;
      lir_pkg::ST_CHK: state_d = in_range ? lir_pkg::ST_RDA : lir_pkg::ST_IDLE;
      lir_pkg::ST_RDA: state_d = lir_pkg::ST_RDB;
      lir_pkg::ST_RDB: begin
        ram_raddr = j_q + lir_pkg::ADDR_W'(1);
        state_d   = lir_pkg::ST_MAC;
      end
      lir_pkg::ST_MAC: state_d = lir_pkg::ST_IDLE;
      default: state_d = lir_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state_q != lir_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= lir_pkg::COUNT_RESET;
      start_pos_q <= lir_pkg::START_RESET;
      step_q      <= lir_pkg::STEP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lir_pkg::REG_SRC_COUNT: count_q     <= cfg_wdata_i[lir_pkg::COUNT_W-1:0];
        lir_pkg::REG_START_POS: start_pos_q <= cfg_wdata_i;
        lir_pkg::REG_STEP:      step_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= ((state_q == lir_pkg::ST_CHK) && !in_range) ||
                     (state_q == lir_pkg::ST_MAC);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (cmd_i == lir_pkg::CMD_COMPUTE)) begin
      idx_q <= index_i;
    end
    if (state_q == lir_pkg::ST_MUL) begin
      prod_q <= $signed({1'b0, idx_q}) * step_q;
    end
    if (state_q == lir_pkg::ST_CHK) begin
      j_q         <= pos[lir_pkg::FRAC_BITS +: lir_pkg::ADDR_W];
      f_q         <= pos[lir_pkg::FRAC_BITS-1:0];
      out_index_q <= idx_q;
      out_value_q <= '0;
      out_oor_q   <= !in_range;
    end
    if (state_q == lir_pkg::ST_RDB) begin
      acc_q <= lir_pkg::ACC_W'((lir_pkg::FIX_ONE - (lir_pkg::FRAC_BITS + 1)'(f_q)) *
                               ram_rdata);
    end
    if (state_q == lir_pkg::ST_MAC) begin
      out_value_q <= acc_d[lir_pkg::FRAC_BITS +: lir_pkg::SAMPLE_W];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_index_o    = out_index_q;
  assign out_value_o    = out_value_q;
  assign out_of_range_o = out_oor_q;

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !busy)
    else $error("result shown while busy");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o)
    else $error("result strobe longer than one cycle");

  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i == lir_pkg::CMD_COMPUTE)) |=> busy)
    else $error("compute word accepted without going busy");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |-> (out_value_o == '0))
    else $error("out-of-range result with nonzero value");

endmodule

### bench/linear_interp_resampler_check.sv
`timescale 1ns / 1ps
// Resampler checker: tracks registers and sample memory, predicts result words and compares them.
module linear_interp_resampler_check
  import lir_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic                 cmd_i,
  input  logic [IDX_W-1:0]     index_i,
  input  logic [SAMPLE_W-1:0]  sample_value_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 out_valid_i,
  input  logic [IDX_W-1:0]     out_index_i,
  input  logic [SAMPLE_W-1:0]  out_value_i,
  input  logic                 out_of_range_i,
  output int unsigned          pending_o,
  output int unsigned          fail_count_o
);

  typedef struct packed {
    logic [IDX_W-1:0]    index;
    logic [SAMPLE_W-1:0] value;
    logic                oor;
  } interp_word_t;

  logic [SAMPLE_W-1:0] sample_mem [SRC_DEPTH];
  logic [COUNT_W-1:0]  count_q;
  logic [POS_W-1:0]    start_q;
  logic [POS_W-1:0]    step_q;
  interp_word_t        interp_words_q [$];
  int unsigned         fails;

  initial begin
    for (int i = 0; i < SRC_DEPTH; i++) sample_mem[i] = '0;
  end

  function automatic interp_word_t interp_sample(input logic [IDX_W-1:0] idx);
    interp_word_t w;
    longint       eff_count;
    longint       pos;
    longint       j;
    longint       f;
    longint       acc;
    longint       unit;
    unit      = longint'(1) <<< FRAC_BITS;
    eff_count = (longint'(count_q) > longint'(SRC_DEPTH)) ? longint'(SRC_DEPTH)
                                                          : longint'(count_q);
    pos       = longint'($signed(start_q)) + longint'(idx) * longint'($signed(step_q));
    w.index   = idx;
    w.value   = '0;
    w.oor     = 1'b1;
    if (eff_count > 0 && pos >= 0 && pos <= ((eff_count - 1) <<< FRAC_BITS)) begin
      j   = pos >>> FRAC_BITS;
      f   = pos & (unit - 1);
      acc = (unit - f) * longint'(sample_mem[j]);
      if (f != 0 && j + 1 < longint'(SRC_DEPTH)) begin
        acc += f * longint'(sample_mem[j + 1]);
      end
      acc    += unit >>> 1;
      w.value = SAMPLE_W'(acc >>> FRAC_BITS);
      w.oor   = 1'b0;
    end
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    interp_word_t got;
    interp_word_t want;
    if (!rst_ni) begin
      count_q = COUNT_RESET;
      start_q = START_RESET;
      step_q  = STEP_RESET;
      interp_words_q.delete();
      fails   = 0;
    end else begin
      if (out_valid_i) begin
        got = '{index: out_index_i, value: out_value_i, oor: out_of_range_i};
        if (interp_words_q.size() == 0) begin
          $error("unexpected result word: out_index %0d out_value %0d out_of_range %0b",
                 got.index, got.value, got.oor);
          fails++;
        end else begin
          want = interp_words_q.pop_front();
          if (got.index !== want.index) begin
            $error("out_index: expected %0d, actual %0d", want.index, got.index);
            fails++;
          end
          if (got.value !== want.value) begin
            $error("out_value: expected %0d, actual %0d", want.value, got.value);
            fails++;
          end
          if (got.oor !== want.oor) begin
            $error("out_of_range: expected %0b, actual %0b", want.oor, got.oor);
            fails++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SRC_COUNT: count_q = cfg_wdata_i[COUNT_W-1:0];
          REG_START_POS: start_q = cfg_wdata_i[POS_W-1:0];
          REG_STEP:      step_q  = cfg_wdata_i[POS_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        if (cmd_i == CMD_LOAD) begin
          sample_mem[index_i] = sample_value_i;
        end else begin
          interp_words_q.push_back(interp_sample(index_i));
        end
      end
    end
    pending_o    <= interp_words_q.size();
    fail_count_o <= fails;
  end

endmodule

### bench/linear_interp_resampler_unit_tb.sv
`timescale 1ns / 1ps
// Resampler testbench top: clock, reset, load and compute stimulus, watchdog and verdict.
module linear_interp_resampler_unit_tb;
  import lir_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int unsigned IDLE_PCT     = 37;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned PHASES       = 7;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned FIX_UNIT     = 1 << FRAC_BITS;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic                 cmd_i;
  logic [IDX_W-1:0]     index_i;
  logic [SAMPLE_W-1:0]  sample_value_i;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 out_valid_o;
  logic [IDX_W-1:0]     out_index_o;
  logic [SAMPLE_W-1:0]  out_value_o;
  logic                 out_of_range_o;
  int unsigned          pending;
  int unsigned          fail_count;

  bit [SRC_DEPTH-1:0]   loaded;
  logic [COUNT_W-1:0]   set_count;
  logic [POS_W-1:0]     set_start;
  logic [POS_W-1:0]     set_step;
  bit                   no_idle;
  int unsigned          stall_cycles;

  linear_interp_resampler_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .index_i        (index_i),
    .sample_value_i (sample_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (out_valid_o),
    .out_index_o    (out_index_o),
    .out_value_o    (out_value_o),
    .out_of_range_o (out_of_range_o)
  );

  linear_interp_resampler_check u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .cmd_i          (cmd_i),
    .index_i        (index_i),
    .sample_value_i (sample_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_i    (out_valid_o),
    .out_index_i    (out_index_o),
    .out_value_i    (out_value_o),
    .out_of_range_i (out_of_range_o),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || out_valid_o || cfg_we_i) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_word(input logic c, input logic [IDX_W-1:0] idx,
                           input logic [SAMPLE_W-1:0] val);
    int unsigned gap;
    gap = 0;
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    cmd_i          <= c;
    index_i        <= idx;
    sample_value_i <= val;
    do @(posedge clk_i); while (busy);
    if (c == CMD_LOAD) loaded[idx] = 1'b1;
  endtask

  // Loads any sample the interpolation would read before that word is sent.
  task automatic compute_word(input logic [IDX_W-1:0] idx);
    longint eff;
    longint pos;
    longint j;
    eff = (longint'(set_count) > longint'(SRC_DEPTH)) ? longint'(SRC_DEPTH)
                                                      : longint'(set_count);
    pos = longint'($signed(set_start)) + longint'(idx) * longint'($signed(set_step));
    if (eff > 0 && pos >= 0 && pos <= ((eff - 1) <<< FRAC_BITS)) begin
      j = pos >>> FRAC_BITS;
      if (!loaded[j]) send_word(CMD_LOAD, IDX_W'(j), SAMPLE_W'($urandom));
      if ((pos & longint'(FIX_UNIT - 1)) != 0 && !loaded[j + 1]) begin
        send_word(CMD_LOAD, IDX_W'(j + 1), SAMPLE_W'($urandom));
      end
    end
    send_word(CMD_COMPUTE, idx, SAMPLE_W'($urandom));
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [COUNT_W-1:0] count, input logic [POS_W-1:0] pos0,
                              input logic [POS_W-1:0] inc, input bit spare);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_SRC_COUNT;
    cfg_wdata_i <= CFG_W'({19'($urandom), count});
    @(posedge clk_i);
    cfg_idx_i   <= REG_START_POS;
    cfg_wdata_i <= pos0;
    @(posedge clk_i);
    cfg_idx_i   <= REG_STEP;
    cfg_wdata_i <= inc;
    @(posedge clk_i);
    if (spare) begin
      cfg_idx_i   <= REG_SPARE;
      cfg_wdata_i <= $urandom;
      @(posedge clk_i);
    end
    cfg_we_i  <= 1'b0;
    set_count = count;
    set_start = pos0;
    set_step  = inc;
  endtask

  initial begin
    logic [COUNT_W-1:0] count;
    int unsigned        eff;
    longint             span;
    logic [POS_W-1:0]   pos0;
    logic [POS_W-1:0]   inc;
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    cmd_i          <= CMD_LOAD;
    index_i        <= '0;
    sample_value_i <= '0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= REG_SRC_COUNT;
    cfg_wdata_i    <= '0;
    loaded         = '0;
    no_idle        = 1'b0;
    set_count      = COUNT_RESET;
    set_start      = START_RESET;
    set_step       = STEP_RESET;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // half-sample steps over four samples, including the last sample and just past it
    program_regs(COUNT_W'(4), '0, POS_W'(FIX_UNIT / 2), 1'b1);
    send_word(CMD_LOAD, IDX_W'(0), 8'h00);
    send_word(CMD_LOAD, IDX_W'(1), 8'hFF);
    send_word(CMD_LOAD, IDX_W'(2), 8'h80);
    send_word(CMD_LOAD, IDX_W'(3), 8'h01);
    compute_word(IDX_W'(0));
    compute_word(IDX_W'(1));
    compute_word(IDX_W'(3));
    compute_word(IDX_W'(6));
    compute_word(IDX_W'(7));
    compute_word('1);
    // empty source
    program_regs('0, '0, STEP_RESET, 1'b0);
    compute_word(IDX_W'(0));
    // just below zero, then tiny fractions
    program_regs(COUNT_W'(2), '1, POS_W'(1), 1'b0);
    compute_word(IDX_W'(0));
    compute_word(IDX_W'(1));
    compute_word('1);
    // saturated count, exactly on the last sample, most negative step
    program_regs('1, POS_W'((SRC_DEPTH - 1) * FIX_UNIT), 32'h8000_0000, 1'b0);
    compute_word(IDX_W'(0));
    compute_word(IDX_W'(1));
    program_regs(COUNT_W'(SRC_DEPTH), 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    compute_word(IDX_W'(0));
    compute_word(IDX_W'(1));
    compute_word('1);
    program_regs(COUNT_W'(SRC_DEPTH), 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    compute_word(IDX_W'(0));
    compute_word(IDX_W'(1));

    for (int phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(9))
        0:       count = '0;
        1:       count = COUNT_W'(1);
        2:       count = COUNT_W'(SRC_DEPTH);
        3:       count = COUNT_W'($urandom);
        default: count = COUNT_W'($urandom_range(2, 48));
      endcase
      eff  = (count > SRC_DEPTH) ? SRC_DEPTH : count;
      span = (eff == 0) ? 0 : longint'(eff - 1) * FIX_UNIT;
      if ($urandom_range(3) != 0) begin
        pos0 = POS_W'(longint'($urandom_range(0, int'(span)))
                      - longint'($urandom_range(0, 2 * FIX_UNIT)));
        inc  = POS_W'(longint'($urandom_range(0, 2 * FIX_UNIT)) - FIX_UNIT);
      end else begin
        pos0 = $urandom;
        inc  = $urandom;
      end
      program_regs(count, pos0, inc, $urandom_range(3) == 0);
      no_idle = (phase == 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(99) < 35) begin
          if (eff > 0 && $urandom_range(9) < 7) begin
            send_word(CMD_LOAD, IDX_W'($urandom_range(0, eff - 1)), SAMPLE_W'($urandom));
          end else begin
            send_word(CMD_LOAD, IDX_W'($urandom), SAMPLE_W'($urandom));
          end
        end else if ($urandom_range(99) < 80) begin
          compute_word(IDX_W'($urandom_range(0, 63)));
        end else begin
          compute_word(IDX_W'($urandom));
        end
      end
      no_idle = 1'b0;
    end

    drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/lir_pkg.sv
hdl/lir_ram.sv
hdl/linear_interp_resampler_unit.sv
bench/linear_interp_resampler_check.sv
bench/linear_interp_resampler_unit_tb.sv
